@@ rtl/idp_pkg.sv @@
// Shared types and constants for the int8 dot-product register device.
// Used by idp_regs, idp_mac and int8_dot_product_register_device_core.
package idp_pkg;

  localparam int WORD_W = 32;
  localparam int OFF_W  = 3;
  localparam int BYTE_W = 8;
  localparam int PROD_W = 2 * BYTE_W;
  // |sum| <= 8 * 128 * 128 = 2^17, so 19 signed bits suffice
  localparam int ACC_W  = 19;
  localparam int LANES  = 4;
  localparam int STEPS  = 2 * LANES;
  localparam int CNT_W  = 4;

  localparam logic [OFF_W-1:0] OFF_CTRL   = 3'd0;
  localparam logic [OFF_W-1:0] OFF_A      = 3'd1;
  localparam logic [OFF_W-1:0] OFF_B      = 3'd2;
  localparam logic [OFF_W-1:0] OFF_C      = 3'd3;
  localparam logic [OFF_W-1:0] OFF_D      = 3'd4;
  localparam logic [OFF_W-1:0] OFF_RESULT = 3'd5;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam int GO_BIT   = 0;
  localparam int DONE_BIT = 31;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_CALC = 1'b1
  } seq_state_t;

  typedef struct packed {
    logic              accept;
    logic              func;
    logic [OFF_W-1:0]  offset;
    logic [WORD_W-1:0] data;
  } bus_req_t;

endpackage

@@ rtl/idp_regs.sv @@
// Register file of the dot-product device: operands, control flags, result.
// Depends on idp_pkg; sum updates come from idp_mac.
module idp_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  idp_pkg::bus_req_t                req,
  input  logic                             sum_load,
  input  logic [idp_pkg::WORD_W-1:0]       sum_in,
  output logic [idp_pkg::WORD_W-1:0]       rd_data,
  output logic [idp_pkg::WORD_W-1:0]       operand_a,
  output logic [idp_pkg::WORD_W-1:0]       operand_b,
  output logic [idp_pkg::WORD_W-1:0]       operand_c,
  output logic [idp_pkg::WORD_W-1:0]       operand_d
);

  logic                       go_flag;
  logic                       done_flag;
  logic [idp_pkg::WORD_W-1:0] sum_word;
  logic                       wr;

  assign wr = req.accept && (req.func == idp_pkg::FUNC_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      operand_a <= '0;
      operand_b <= '0;
      operand_c <= '0;
      operand_d <= '0;
      go_flag   <= 1'b0;
      done_flag <= 1'b0;
      sum_word  <= '0;
    end else begin
      if (wr) begin
        unique case (req.offset)
          idp_pkg::OFF_CTRL: begin
            go_flag   <= req.data[idp_pkg::GO_BIT];
            done_flag <= req.data[idp_pkg::GO_BIT];
          end
          idp_pkg::OFF_A: operand_a <= req.data;
          idp_pkg::OFF_B: operand_b <= req.data;
          idp_pkg::OFF_C: operand_c <= req.data;
          idp_pkg::OFF_D: operand_d <= req.data;
          default: ;
        endcase
      end
      if (sum_load) begin
        sum_word <= sum_in;
      end
    end
  end

  always_comb begin
    rd_data = '0;
    unique case (req.offset)
      idp_pkg::OFF_CTRL: begin
        rd_data[idp_pkg::GO_BIT]   = go_flag;
        rd_data[idp_pkg::DONE_BIT] = done_flag;
      end
      idp_pkg::OFF_A:      rd_data = operand_a;
      idp_pkg::OFF_B:      rd_data = operand_b;
      idp_pkg::OFF_C:      rd_data = operand_c;
      idp_pkg::OFF_D:      rd_data = operand_d;
      idp_pkg::OFF_RESULT: rd_data = sum_word;
      default:             rd_data = '0;
    endcase
  end

endmodule

@@ rtl/idp_mac.sv @@
// Shared 8x8 signed multiplier and accumulator stepping over the eight byte pairs.
// Depends on idp_pkg; started and observed by the top-level sequencer.
module idp_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [idp_pkg::WORD_W-1:0] operand_a,
  input  logic [idp_pkg::WORD_W-1:0] operand_b,
  input  logic [idp_pkg::WORD_W-1:0] operand_c,
  input  logic [idp_pkg::WORD_W-1:0] operand_d,
  output logic                       done,
  output logic [idp_pkg::WORD_W-1:0] sum
);

  logic                              busy;
  logic [idp_pkg::CNT_W-1:0]         cnt;
  logic                              prod_vld;
  logic signed [idp_pkg::PROD_W-1:0] prod;
  logic signed [idp_pkg::ACC_W-1:0]  acc;
  logic signed [idp_pkg::ACC_W-1:0]  acc_next;
  logic [idp_pkg::WORD_W-1:0]        x_word;
  logic [idp_pkg::WORD_W-1:0]        y_word;
  logic signed [idp_pkg::BYTE_W-1:0] x_byte;
  logic signed [idp_pkg::BYTE_W-1:0] y_byte;
  logic                              last;

  // Steps 0..3 walk A.B, steps 4..7 walk C.D
  assign x_word = cnt[2] ? operand_c : operand_a;
  assign y_word = cnt[2] ? operand_d : operand_b;
  assign x_byte = x_word[cnt[1:0]*idp_pkg::BYTE_W +: idp_pkg::BYTE_W];
  assign y_byte = y_word[cnt[1:0]*idp_pkg::BYTE_W +: idp_pkg::BYTE_W];

  assign last = busy && (cnt == idp_pkg::CNT_W'(idp_pkg::STEPS));

  always_comb begin
    acc_next = acc;
    if (prod_vld) begin
      acc_next = acc + {{(idp_pkg::ACC_W-idp_pkg::PROD_W){prod[idp_pkg::PROD_W-1]}}, prod};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      prod_vld <= 1'b0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      prod_vld <= 1'b0;
    end else if (busy) begin
      if (last) begin
        busy     <= 1'b0;
        prod_vld <= 1'b0;
      end else begin
        cnt      <= cnt + 1'b1;
        prod_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
    prod <= x_byte * y_byte;
  end

  assign done = last;
  assign sum  = {{(idp_pkg::WORD_W-idp_pkg::ACC_W){acc_next[idp_pkg::ACC_W-1]}}, acc_next};

  default disable iff (rst);

  a_start_busy: assert property (@(posedge clk) start |=> busy && (cnt == '0))
    else $error("mac did not start clean");
  a_done_idle: assert property (@(posedge clk) done |=> !busy)
    else $error("mac still busy after done");
  a_cnt_range: assert property (@(posedge clk)
    busy |-> (cnt <= idp_pkg::CNT_W'(idp_pkg::STEPS)))
    else $error("mac step count overran");

endmodule

@@ rtl/int8_dot_product_register_device_core.sv @@
// Register access: the response is registered in the output register, or in the
// skid entry while the output stalls; one request per cycle when nothing stalls.
// Control write with Go set: the response is registered as for any request, then
// the shared multiplier walks the eight byte pairs and ready stays low until done.
// Synchronous active-high reset clears operand registers, flags and result to zero.
module int8_dot_product_register_device_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [idp_pkg::OFF_W-1:0]  word_offset,
  input  logic [idp_pkg::WORD_W-1:0] write_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [idp_pkg::WORD_W-1:0] read_word
);

  idp_pkg::seq_state_t        state;
  idp_pkg::seq_state_t        state_next;
  idp_pkg::bus_req_t          req;
  logic                       accept;
  logic                       go_start;
  logic                       mac_done;
  logic [idp_pkg::WORD_W-1:0] mac_sum;
  logic [idp_pkg::WORD_W-1:0] rd_data;
  logic [idp_pkg::WORD_W-1:0] resp;
  logic [idp_pkg::WORD_W-1:0] operand_a;
  logic [idp_pkg::WORD_W-1:0] operand_b;
  logic [idp_pkg::WORD_W-1:0] operand_c;
  logic [idp_pkg::WORD_W-1:0] operand_d;
  logic                       skid_valid;
  logic [idp_pkg::WORD_W-1:0] skid_word;

  assign accept     = in_valid && in_ready;
  assign req.accept = accept;
  assign req.func   = func;
  assign req.offset = word_offset;
  assign req.data   = write_word;

  assign go_start = accept && (func == idp_pkg::FUNC_WRITE) &&
                    (word_offset == idp_pkg::OFF_CTRL) && write_word[idp_pkg::GO_BIT];

  // Writes answer zero
  assign resp = (func == idp_pkg::FUNC_WRITE) ? '0 : rd_data;

  idp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .sum_load  (mac_done),
    .sum_in    (mac_sum),
    .rd_data   (rd_data),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .operand_c (operand_c),
    .operand_d (operand_d)
  );

  idp_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .start     (go_start),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .operand_c (operand_c),
    .operand_d (operand_d),
    .done      (mac_done),
    .sum       (mac_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      idp_pkg::ST_IDLE: if (go_start) state_next = idp_pkg::ST_CALC;
      idp_pkg::ST_CALC: if (mac_done) state_next = idp_pkg::ST_IDLE;
      default:          state_next = idp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == idp_pkg::ST_IDLE) && !skid_valid;
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        read_word <= skid_word;
      end else if (accept) begin
        read_word <= resp;
      end
    end else if (accept) begin
      skid_word <= resp;
    end
  end

  default disable iff (rst);

  a_go_blocks: assert property (@(posedge clk) go_start |=> !in_ready)
    else $error("request taken while dot product runs");
  a_done_in_calc: assert property (@(posedge clk) mac_done |-> (state == idp_pkg::ST_CALC))
    else $error("mac finished outside calc state");
  a_skid_behind_out: assert property (@(posedge clk) skid_valid |-> out_valid)
    else $error("skid entry held with output empty");
  a_skid_no_accept: assert property (@(posedge clk) skid_valid |-> !accept)
    else $error("request taken with skid full");

endmodule
